@@ rtl/gcob_pkg.sv @@
// Shared constants, codes and types of the grid cell object bins unit.
package gcob_pkg;

   localparam int DEF_MAX_HALF_SIDE = 8;
   localparam int DEF_CELL_CAPACITY = 16;

   localparam int CFG_W       = 4;
   localparam int ACT_W       = 3;
   localparam int COORD_W     = 5;
   localparam int ID_W        = 16;
   localparam int SLOT_W      = 4;
   localparam int STATUS_W    = 2;
   localparam int COUNT_OUT_W = 9;
   localparam int NBR_COUNT   = 9;
   localparam int NBR_IDX_W   = 4;

   localparam logic [CFG_W-1:0] CFG_HALF_RESET = 4'd2;

   localparam logic CSR_HALF_WIDTH  = 1'b0;
   localparam logic CSR_HALF_HEIGHT = 1'b1;

   localparam logic [ACT_W-1:0] ACT_REGISTER   = 3'd0;
   localparam logic [ACT_W-1:0] ACT_UNREGISTER = 3'd1;
   localparam logic [ACT_W-1:0] ACT_SET_CULL   = 3'd2;
   localparam logic [ACT_W-1:0] ACT_READ_FLAG  = 3'd3;
   localparam logic [ACT_W-1:0] ACT_NEIGHBOURS = 3'd4;

   localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD  = 2'd2;

   typedef enum logic [5:0] {
      S_IDLE    = 6'b000001,
      S_READ    = 6'b000010,
      S_EXEC    = 6'b000100,
      S_MOVE    = 6'b001000,
      S_NBR     = 6'b010000,
      S_NBR_OUT = 6'b100000
   } state_type;

   // Listing order: centre, left, right, below, above, then the four diagonals.
   function automatic logic signed [1:0] nbr_dx(input logic [NBR_IDX_W-1:0] k);
      logic signed [1:0] d;
      case (k)
         4'd1, 4'd5, 4'd7: d = -2'sd1;
         4'd2, 4'd6, 4'd8: d = 2'sd1;
         default:          d = 2'sd0;
      endcase
      return d;
   endfunction

   function automatic logic signed [1:0] nbr_dy(input logic [NBR_IDX_W-1:0] k);
      logic signed [1:0] d;
      case (k)
         4'd3, 4'd5, 4'd6: d = -2'sd1;
         4'd4, 4'd7, 4'd8: d = 2'sd1;
         default:          d = 2'sd0;
      endcase
      return d;
   endfunction

endpackage

@@ rtl/grid_cell_object_bins_unit.sv @@
// Grid cell object bins: per-cell object lists, active cell list and frustum flags.
// Each result is registered; a new item is accepted only in the idle state, after the result
//   of the previous item has gone into the output register. A neighbour listing gives one
//   result per listed cell and skips positions off the grid; a stalled result holds the unit.
// Reset (synchronous) and any csr write clear the entry valid bits and the active count.
module grid_cell_object_bins_unit
   import gcob_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_enable,
   input  logic                       csr_index,
   input  logic [CFG_W-1:0]           csr_write_data,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [ACT_W-1:0]           req_action,
   input  logic signed [COORD_W-1:0]  req_cell_x,
   input  logic signed [COORD_W-1:0]  req_cell_y,
   input  logic [ID_W-1:0]            req_object_id,
   input  logic [SLOT_W-1:0]          req_slot_index,
   input  logic                       req_culled,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic [SLOT_W-1:0]          rsp_assigned_slot,
   output logic [ID_W-1:0]            rsp_moved_object,
   output logic                       rsp_moved_valid,
   output logic                       rsp_in_frustum,
   output logic signed [COORD_W-1:0]  rsp_neighbour_x,
   output logic signed [COORD_W-1:0]  rsp_neighbour_y,
   output logic [COUNT_OUT_W-1:0]     rsp_active_cells,
   output logic                       rsp_last
);

   localparam int MAX_HALF_SIDE = DEF_MAX_HALF_SIDE;
   localparam int CELL_CAPACITY = DEF_CELL_CAPACITY;
   localparam int GRID_SIDE  = 2 * MAX_HALF_SIDE;
   localparam int GRID_CELLS = GRID_SIDE * GRID_SIDE;
   localparam int XW         = $clog2(GRID_SIDE);
   localparam int CW         = 2 * XW;
   localparam int CELL_NUM   = 2 ** CW;
   localparam int HW         = $clog2(MAX_HALF_SIDE + 1);
   localparam int HCW        = (HW > CFG_W) ? HW : CFG_W;
   localparam int SW         = ((XW > COORD_W) ? XW : COORD_W) + 2;
   localparam int FW         = $clog2(CELL_CAPACITY + 1);
   localparam int SLW        = $clog2(CELL_CAPACITY);
   localparam int SCW        = FW + SLOT_W;
   localparam int SAW        = CW + SLW;
   localparam int CNT_W      = $clog2(GRID_CELLS + 1);

   state_type                 state_ff, state_in;
   logic [CFG_W-1:0]          half_w_ff, half_h_ff;
   logic [HW-1:0]             hw_eff, hh_eff;
   logic [ACT_W-1:0]          action_ff;
   logic [XW-1:0]             cx_ff, cy_ff;
   logic [ID_W-1:0]           id_ff;
   logic [SLOT_W-1:0]         slot_ff;
   logic                      culled_ff;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [NBR_IDX_W-1:0]      k_ff, k_in;
   logic [NBR_COUNT-1:0]      mask_ff, mask_in, mask_calc;
   logic [CW-1:0]             cell_addr;

   // memories and their registered read data
   logic [FW:0]               bin_mem  [CELL_NUM];
   logic [ID_W-1:0]           slot_mem [2**SAW];
   logic [CW-1:0]             list_mem [CELL_NUM];
   logic [CW-1:0]             pos_mem  [CELL_NUM];
   logic [CELL_NUM-1:0]       bin_vld_ff;
   logic [FW:0]               bin_rd_ff;
   logic                      bin_vld_rd_ff;
   logic [ID_W-1:0]           slot_rd_ff;
   logic [CW-1:0]             list_rd_ff, pos_rd_ff;

   logic                      fill_we, fr_we, slot_we, list_we, pos_we;
   logic [FW-1:0]             fill_wd;
   logic                      fr_wd;
   logic [SAW-1:0]            slot_wa, slot_ra;
   logic [ID_W-1:0]           slot_wd;
   logic [CW-1:0]             list_wa, list_wd, list_ra, pos_wa, pos_wd, frd_addr;

   logic [FW-1:0]             fill_eff, last_slot;
   logic                      fr_eff, unreg_bad, out_free, emit, later;
   logic signed [SW-1:0]      cx_s, cy_s, nx_s, ny_s, hw2_s, hh2_s;

   // output register
   logic                      rsp_valid_ff;
   logic [STATUS_W-1:0]       status_ff, status_in;
   logic [SLOT_W-1:0]         aslot_ff, aslot_in;
   logic [ID_W-1:0]           moved_ff, moved_in;
   logic                      mvalid_ff, mvalid_in, infr_ff, infr_in, last_ff, last_in;
   logic signed [COORD_W-1:0] nbx_ff, nbx_in, nby_ff, nby_in;
   logic [CNT_W-1:0]          acells_ff;

   function automatic logic [HW-1:0] eff_half(input logic [CFG_W-1:0] r);
      logic [HW-1:0] h;
      if (r == '0)
         h = HW'(1);
      else if (HCW'(r) > HCW'(MAX_HALF_SIDE))
         h = HW'(MAX_HALF_SIDE);
      else
         h = HW'(r);
      return h;
   endfunction

   function automatic logic [XW-1:0] to_index(input logic signed [COORD_W-1:0] w,
                                              input logic [HW-1:0] half);
      logic signed [SW-1:0] ws, hs, r;
      ws = SW'(w);
      hs = SW'(half);
      if (ws > hs)  ws = hs;
      if (ws < -hs) ws = -hs;
      if (ws == SW'(0)) ws = SW'(1);
      r = (ws > SW'(0)) ? (ws + hs - SW'(1)) : (ws + hs);
      return XW'(r);
   endfunction

   function automatic logic signed [COORD_W-1:0] to_world(input logic signed [SW-1:0] idx,
                                                          input logic [HW-1:0] half);
      logic signed [SW-1:0] w;
      w = idx - SW'(half);
      if (w >= SW'(0)) w = w + SW'(1);
      return COORD_W'(w);
   endfunction

   assign hw_eff   = eff_half(half_w_ff);
   assign hh_eff   = eff_half(half_h_ff);
   assign cell_addr = {cy_ff, cx_ff};
   assign req_ready = (state_ff == S_IDLE);
   assign out_free = !rsp_valid_ff || rsp_ready;

   assign fill_eff  = bin_vld_rd_ff ? bin_rd_ff[FW-1:0] : '0;
   assign fr_eff    = bin_vld_rd_ff & bin_rd_ff[FW];
   assign last_slot = fill_eff - FW'(1);
   assign unreg_bad = (fill_eff == '0) || (SCW'(slot_ff) >= SCW'(fill_eff));

   assign cx_s  = SW'($signed({1'b0, cx_ff}));
   assign cy_s  = SW'($signed({1'b0, cy_ff}));
   assign hw2_s = SW'({hw_eff, 1'b0});
   assign hh2_s = SW'({hh_eff, 1'b0});
   assign nx_s  = cx_s + SW'(nbr_dx(k_ff));
   assign ny_s  = cy_s + SW'(nbr_dy(k_ff));

   assign frd_addr = (action_ff == ACT_NEIGHBOURS) ? {XW'(ny_s), XW'(nx_s)} : cell_addr;
   assign slot_ra  = {cell_addr, SLW'(last_slot)};
   assign list_ra  = CW'(count_ff - CNT_W'(1));

   // Which of the nine listing positions fall inside the grid.
   always_comb begin : mask_blk
      logic signed [SW-1:0] tx, ty;
      mask_calc = '0;
      for (int j = 0; j < NBR_COUNT; j++) begin
         tx = cx_s + SW'(nbr_dx(NBR_IDX_W'(j)));
         ty = cy_s + SW'(nbr_dy(NBR_IDX_W'(j)));
         mask_calc[j] = (tx >= SW'(0)) && (tx < hw2_s) && (ty >= SW'(0)) && (ty < hh2_s);
      end
   end

   always_comb begin
      later = 1'b0;
      for (int j = 0; j < NBR_COUNT; j++) begin
         if ((NBR_IDX_W'(j) > k_ff) && mask_ff[j]) later = 1'b1;
      end
   end

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      k_in      = k_ff;
      mask_in   = mask_ff;
      emit      = 1'b0;
      status_in = STATUS_OK;
      aslot_in  = '0;
      moved_in  = '0;
      mvalid_in = 1'b0;
      infr_in   = 1'b0;
      nbx_in    = '0;
      nby_in    = '0;
      last_in   = 1'b1;
      fill_we   = 1'b0;
      fill_wd   = fill_eff + FW'(1);
      fr_we     = 1'b0;
      fr_wd     = !culled_ff;
      slot_we   = 1'b0;
      slot_wa   = {cell_addr, SLW'(fill_eff)};
      slot_wd   = id_ff;
      list_we   = 1'b0;
      list_wa   = CW'(count_ff);
      list_wd   = cell_addr;
      pos_we    = 1'b0;
      pos_wa    = cell_addr;
      pos_wd    = CW'(count_ff);
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_READ;
         end
         S_READ: begin
            mask_in  = mask_calc;
            k_in     = '0;
            state_in = (action_ff == ACT_NEIGHBOURS) ? S_NBR : S_EXEC;
         end
         S_EXEC: begin
            case (action_ff)
               ACT_REGISTER: begin
                  if (out_free) begin
                     emit     = 1'b1;
                     state_in = S_IDLE;
                     if (fill_eff >= FW'(CELL_CAPACITY)) begin
                        status_in = STATUS_FULL;
                     end else begin
                        slot_we  = 1'b1;
                        fill_we  = 1'b1;
                        aslot_in = SLOT_W'(fill_eff);
                        // first object in the cell: append it to the active list
                        if ((fill_eff == '0) && (count_ff < CNT_W'(GRID_CELLS))) begin
                           list_we  = 1'b1;
                           pos_we   = 1'b1;
                           count_in = count_ff + CNT_W'(1);
                        end
                     end
                  end
               end
               ACT_UNREGISTER: begin
                  if (!unreg_bad) begin
                     state_in = S_MOVE;
                  end else if (out_free) begin
                     emit      = 1'b1;
                     status_in = STATUS_BAD;
                     state_in  = S_IDLE;
                  end
               end
               ACT_SET_CULL: begin
                  if (out_free) begin
                     emit     = 1'b1;
                     fr_we    = 1'b1;
                     infr_in  = !culled_ff;
                     state_in = S_IDLE;
                  end
               end
               ACT_READ_FLAG: begin
                  if (out_free) begin
                     emit     = 1'b1;
                     infr_in  = fr_eff;
                     state_in = S_IDLE;
                  end
               end
               default: begin
                  if (out_free) begin
                     emit     = 1'b1;
                     state_in = S_IDLE;
                  end
               end
            endcase
         end
         S_MOVE: begin
            if (out_free) begin
               emit     = 1'b1;
               state_in = S_IDLE;
               fill_we  = 1'b1;
               fill_wd  = last_slot;
               // swap the cell's last id into the freed slot
               if (SCW'(slot_ff) != SCW'(last_slot)) begin
                  slot_we   = 1'b1;
                  slot_wa   = {cell_addr, SLW'(slot_ff)};
                  slot_wd   = slot_rd_ff;
                  moved_in  = slot_rd_ff;
                  mvalid_in = 1'b1;
               end
               // cell emptied: swap-remove it from the active list
               if ((last_slot == '0) && (count_ff != '0)) begin
                  count_in = count_ff - CNT_W'(1);
                  if (CNT_W'(pos_rd_ff) != count_in) begin
                     list_we = 1'b1;
                     list_wa = pos_rd_ff;
                     list_wd = list_rd_ff;
                     pos_we  = 1'b1;
                     pos_wa  = list_rd_ff;
                     pos_wd  = pos_rd_ff;
                  end
               end
            end
         end
         S_NBR: begin
            if (mask_ff[k_ff])
               state_in = S_NBR_OUT;
            else
               k_in = k_ff + NBR_IDX_W'(1);
         end
         S_NBR_OUT: begin
            if (out_free) begin
               emit    = 1'b1;
               infr_in = fr_eff;
               nbx_in  = to_world(nx_s, hw_eff);
               nby_in  = to_world(ny_s, hh_eff);
               last_in = !later;
               if (later) begin
                  k_in     = k_ff + NBR_IDX_W'(1);
                  state_in = S_NBR;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         k_ff         <= '0;
         mask_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         half_w_ff    <= CFG_HALF_RESET;
         half_h_ff    <= CFG_HALF_RESET;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
         mask_ff  <= mask_in;
         if (csr_write_enable) begin
            count_ff <= '0;
            if (csr_index == CSR_HALF_WIDTH)  half_w_ff <= csr_write_data;
            if (csr_index == CSR_HALF_HEIGHT) half_h_ff <= csr_write_data;
         end else begin
            count_ff <= count_in;
         end
         if (emit)
            rsp_valid_ff <= 1'b1;
         else if (rsp_ready)
            rsp_valid_ff <= 1'b0;
      end
   end

   // item and result payload
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         action_ff <= req_action;
         cx_ff     <= to_index(req_cell_x, hw_eff);
         cy_ff     <= to_index(req_cell_y, hh_eff);
         id_ff     <= req_object_id;
         slot_ff   <= req_slot_index;
         culled_ff <= req_culled;
      end
      if (emit) begin
         status_ff <= status_in;
         aslot_ff  <= aslot_in;
         moved_ff  <= moved_in;
         mvalid_ff <= mvalid_in;
         infr_ff   <= infr_in;
         nbx_ff    <= nbx_in;
         nby_ff    <= nby_in;
         acells_ff <= count_in;
         last_ff   <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || csr_write_enable) begin
         bin_vld_ff <= '0;
      end else begin
         if (fill_we || fr_we) bin_vld_ff[cell_addr] <= 1'b1;
      end
   end

   // each cell word holds {frustum flag, fill}; keep the half that is not updated
   always_ff @(posedge clock) begin
      if (fill_we || fr_we)
         bin_mem[cell_addr] <= {(fr_we ? fr_wd : fr_eff), (fill_we ? fill_wd : fill_eff)};
      if (slot_we) slot_mem[slot_wa] <= slot_wd;
      if (list_we) list_mem[list_wa] <= list_wd;
      if (pos_we)  pos_mem[pos_wa]   <= pos_wd;
      bin_rd_ff      <= bin_mem[frd_addr];
      bin_vld_rd_ff  <= bin_vld_ff[frd_addr];
      slot_rd_ff     <= slot_mem[slot_ra];
      list_rd_ff     <= list_mem[list_ra];
      pos_rd_ff      <= pos_mem[cell_addr];
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_assigned_slot = aslot_ff;
   assign rsp_moved_object  = moved_ff;
   assign rsp_moved_valid   = mvalid_ff;
   assign rsp_in_frustum    = infr_ff;
   assign rsp_neighbour_x   = nbx_ff;
   assign rsp_neighbour_y   = nby_ff;
   assign rsp_active_cells  = COUNT_OUT_W'(acells_ff);
   assign rsp_last          = last_ff;

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(GRID_CELLS))
      else $error("active cell count above grid size");

   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_EXEC && state_ff != S_MOVE && !csr_write_enable) |=> $stable(count_ff))
      else $error("active cell count changed outside an update");

   a_write_with_result: assert property (@(posedge clock) disable iff (reset)
      (fill_we || slot_we || fr_we || list_we || pos_we) |-> (emit && out_free))
      else $error("memory write without a result slot");

   a_centre_listed: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_NBR) |-> mask_ff[0])
      else $error("centre cell missing from listing");

   a_nbr_inside: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_NBR_OUT) |-> mask_ff[k_ff])
      else $error("listing a position off the grid");
`endif

endmodule

@@ tb/sv/grid_cell_object_bins_unit_tb.sv @@
// Self-checking testbench for the grid cell object bins unit.
module grid_cell_object_bins_unit_tb;
   import gcob_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int GRID_SIDE = 2 * DEF_MAX_HALF_SIDE;
   localparam int BIN_CELLS = GRID_SIDE * GRID_SIDE;
   localparam int BIN_CAP   = DEF_CELL_CAPACITY;

   localparam logic [ACT_W-1:0] ACT_UNUSED_LO = 3'd5;
   localparam logic [ACT_W-1:0] ACT_UNUSED_HI = 3'd7;

   typedef enum int {RDY_ALWAYS, RDY_THIRD, RDY_COIN, RDY_BURSTY} ready_mode_type;

   typedef struct {
      logic [ACT_W-1:0]          action;
      logic signed [COORD_W-1:0] cx;
      logic signed [COORD_W-1:0] cy;
      logic [ID_W-1:0]           obj;
      logic [SLOT_W-1:0]         slot;
      logic                      culled;
      bit                        pause;
   } bin_op_type;

   typedef struct {
      logic [STATUS_W-1:0]       status;
      logic [SLOT_W-1:0]         slot;
      logic [ID_W-1:0]           moved;
      logic                      moved_valid;
      logic                      in_frustum;
      logic signed [COORD_W-1:0] nx;
      logic signed [COORD_W-1:0] ny;
      logic [COUNT_OUT_W-1:0]    active;
      logic                      last;
   } bin_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                      csr_write_enable = 1'b0;
   logic                      csr_index = 1'b0;
   logic [CFG_W-1:0]          csr_write_data = '0;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [ACT_W-1:0]          req_action = '0;
   logic signed [COORD_W-1:0] req_cell_x = '0;
   logic signed [COORD_W-1:0] req_cell_y = '0;
   logic [ID_W-1:0]           req_object_id = '0;
   logic [SLOT_W-1:0]         req_slot_index = '0;
   logic                      req_culled = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [STATUS_W-1:0]       rsp_status;
   logic [SLOT_W-1:0]         rsp_assigned_slot;
   logic [ID_W-1:0]           rsp_moved_object;
   logic                      rsp_moved_valid;
   logic                      rsp_in_frustum;
   logic signed [COORD_W-1:0] rsp_neighbour_x;
   logic signed [COORD_W-1:0] rsp_neighbour_y;
   logic [COUNT_OUT_W-1:0]    rsp_active_cells;
   logic                      rsp_last;

   grid_cell_object_bins_unit uut (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_action        (req_action),
      .req_cell_x        (req_cell_x),
      .req_cell_y        (req_cell_y),
      .req_object_id     (req_object_id),
      .req_slot_index    (req_slot_index),
      .req_culled        (req_culled),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_assigned_slot (rsp_assigned_slot),
      .rsp_moved_object  (rsp_moved_object),
      .rsp_moved_valid   (rsp_moved_valid),
      .rsp_in_frustum    (rsp_in_frustum),
      .rsp_neighbour_x   (rsp_neighbour_x),
      .rsp_neighbour_y   (rsp_neighbour_y),
      .rsp_active_cells  (rsp_active_cells),
      .rsp_last          (rsp_last)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 0;
   end

   // Shadow of the grid: configuration, cell contents, active list, frustum flags.
   logic [CFG_W-1:0] half_w = CFG_HALF_RESET;
   logic [CFG_W-1:0] half_h = CFG_HALF_RESET;
   int               bin_fill [BIN_CELLS];
   logic [ID_W-1:0]  bin_slots [BIN_CELLS*BIN_CAP];
   int               active_at [BIN_CELLS];
   int               active_pos [BIN_CELLS];
   int               active_total;
   bit               frustum [BIN_CELLS];
   // Fill counts as the item generator sees them, ahead of the driver.
   int               gen_fill [BIN_CELLS];

   bin_op_type     queued_ops [$];
   bin_result_type due_bin_results [$];
   bin_op_type     cur_op;
   bit             pause_next = 0;

   int ops_queued = 0;
   int ops_taken = 0;
   int results_seen = 0;
   int mismatches = 0;
   int settings_used = 0;

   function automatic int eff_half(input logic [CFG_W-1:0] r);
      if (r == 0) return 1;
      if (r > DEF_MAX_HALF_SIDE) return DEF_MAX_HALF_SIDE;
      return int'(r);
   endfunction

   function automatic int to_index(input int w, input int half);
      int v = w;
      if (v > half) v = half;
      if (v < -half) v = -half;
      if (v == 0) v = 1;
      return (v > 0) ? v + half - 1 : v + half;
   endfunction

   function automatic int to_world(input int idx, input int half);
      int v = idx - half;
      return (v >= 0) ? v + 1 : v;
   endfunction

   function automatic int cell_of(input logic signed [COORD_W-1:0] x,
                                  input logic signed [COORD_W-1:0] y);
      return to_index(y, eff_half(half_h)) * GRID_SIDE + to_index(x, eff_half(half_w));
   endfunction

   function automatic bin_result_type idle_result();
      bin_result_type e;
      e.status = STATUS_OK;
      e.slot = '0;
      e.moved = '0;
      e.moved_valid = 1'b0;
      e.in_frustum = 1'b0;
      e.nx = '0;
      e.ny = '0;
      e.active = '0;
      e.last = 1'b1;
      return e;
   endfunction

   function automatic string result_text(input bin_result_type e);
      return $sformatf("st=%0d slot=%0d mv=%h/%0b fr=%0b xy=%0d,%0d act=%0d last=%0b",
                       e.status, e.slot, e.moved, e.moved_valid, e.in_frustum,
                       e.nx, e.ny, e.active, e.last);
   endfunction

   function automatic void clear_bins();
      for (int k = 0; k < BIN_CELLS; k++) begin
         bin_fill[k] = 0;
         active_at[k] = 0;
         active_pos[k] = 0;
         frustum[k] = 1'b0;
         gen_fill[k] = 0;
      end
      for (int k = 0; k < BIN_CELLS*BIN_CAP; k++) bin_slots[k] = '0;
      active_total = 0;
   endfunction

   // Apply one item to the shadow grid and queue the results it must produce.
   task automatic apply_bin_op(input bin_op_type r);
      int             hw, hh, ix, iy, bin_idx, f, last_slot, pos, other, n, nx, ny, dx, dy;
      int             lx [9];
      int             ly [9];
      bin_result_type e;
      hw = eff_half(half_w);
      hh = eff_half(half_h);
      ix = to_index(r.cx, hw);
      iy = to_index(r.cy, hh);
      bin_idx = iy * GRID_SIDE + ix;
      e = idle_result();
      case (r.action)
         ACT_REGISTER: begin
            f = bin_fill[bin_idx];
            if (f >= BIN_CAP) begin
               e.status = STATUS_FULL;
            end else begin
               if (f == 0 && active_total < BIN_CELLS) begin
                  active_at[active_total] = bin_idx;
                  active_pos[bin_idx] = active_total;
                  active_total++;
               end
               bin_slots[bin_idx*BIN_CAP + f] = r.obj;
               bin_fill[bin_idx] = f + 1;
               e.slot = f[SLOT_W-1:0];
            end
         end
         ACT_UNREGISTER: begin
            f = bin_fill[bin_idx];
            if (f == 0 || int'(r.slot) >= f) begin
               e.status = STATUS_BAD;
            end else begin
               last_slot = f - 1;
               if (int'(r.slot) != last_slot) begin
                  e.moved = bin_slots[bin_idx*BIN_CAP + last_slot];
                  bin_slots[bin_idx*BIN_CAP + int'(r.slot)] = e.moved;
                  e.moved_valid = 1'b1;
               end
               bin_slots[bin_idx*BIN_CAP + last_slot] = '0;
               bin_fill[bin_idx] = last_slot;
               // emptied cell: swap the tail of the active list into its place
               if (last_slot == 0 && active_total > 0) begin
                  pos = active_pos[bin_idx] % BIN_CELLS;
                  active_total--;
                  if (pos != active_total) begin
                     other = active_at[active_total] % BIN_CELLS;
                     active_at[pos] = other;
                     active_pos[other] = pos;
                  end
                  active_at[active_total] = 0;
               end
            end
         end
         ACT_SET_CULL: begin
            frustum[bin_idx] = r.culled ? 1'b0 : 1'b1;
            e.in_frustum = frustum[bin_idx];
         end
         ACT_READ_FLAG: begin
            e.in_frustum = frustum[bin_idx];
         end
         default: ;
      endcase
      if (r.action != ACT_NEIGHBOURS) begin
         e.active = active_total[COUNT_OUT_W-1:0];
         due_bin_results.push_back(e);
      end else begin
         n = 0;
         for (int k = 0; k < 9; k++) begin
            dx = (k == 1 || k == 5 || k == 7) ? -1 : (k == 2 || k == 6 || k == 8) ? 1 : 0;
            dy = (k == 3 || k == 5 || k == 6) ? -1 : (k == 4 || k == 7 || k == 8) ? 1 : 0;
            nx = ix + dx;
            ny = iy + dy;
            if (nx < 0 || nx >= 2*hw || ny < 0 || ny >= 2*hh) continue;
            lx[n] = nx;
            ly[n] = ny;
            n++;
         end
         for (int k = 0; k < n; k++) begin
            e = idle_result();
            e.in_frustum = frustum[ly[k]*GRID_SIDE + lx[k]];
            e.nx = to_world(lx[k], hw);
            e.ny = to_world(ly[k], hh);
            e.active = active_total[COUNT_OUT_W-1:0];
            e.last = (k == n - 1);
            due_bin_results.push_back(e);
         end
      end
   endtask

   task automatic add_op(input logic [ACT_W-1:0] act,
                         input logic signed [COORD_W-1:0] x, y,
                         input logic [ID_W-1:0] obj,
                         input logic [SLOT_W-1:0] slot,
                         input logic culled);
      bin_op_type r;
      int         bin_idx;
      r.action = act;
      r.cx = x;
      r.cy = y;
      r.obj = obj;
      r.slot = slot;
      r.culled = culled;
      r.pause = pause_next;
      pause_next = 0;
      bin_idx = cell_of(x, y);
      if (act == ACT_REGISTER && gen_fill[bin_idx] < BIN_CAP) gen_fill[bin_idx]++;
      if (act == ACT_UNREGISTER && gen_fill[bin_idx] > 0 && int'(slot) < gen_fill[bin_idx])
         gen_fill[bin_idx]--;
      queued_ops.push_back(r);
      ops_queued++;
   endtask

   function automatic logic signed [COORD_W-1:0] rand_coord(input int half);
      int v;
      if ($urandom_range(0, 4) == 0) return COORD_W'($urandom_range(0, 31));
      v = $urandom_range(1, half);
      if ($urandom_range(0, 1) == 1) v = -v;
      return v[COORD_W-1:0];
   endfunction

   task automatic write_grid_cfg(input logic idx, input logic [CFG_W-1:0] val);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= val;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (idx == CSR_HALF_WIDTH) half_w = val;
      else half_h = val;
      clear_bins();
   endtask

   task automatic wait_idle();
      while (ops_taken != ops_queued || due_bin_results.size() != 0) @(posedge clock);
      // let a listing wind down before the grid is touched again
      repeat (12) @(posedge clock);
   endtask

   task automatic random_phase(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                               input int count, input bit fill_first);
      int                        made, pick, hsel, run, bin_idx;
      bit                        paused;
      logic signed [COORD_W-1:0] x, y;
      logic signed [COORD_W-1:0] hot_x [4];
      logic signed [COORD_W-1:0] hot_y [4];
      write_grid_cfg(CSR_HALF_WIDTH, w);
      write_grid_cfg(CSR_HALF_HEIGHT, h);
      settings_used++;
      for (int k = 0; k < 4; k++) begin
         hot_x[k] = rand_coord(eff_half(half_w));
         hot_y[k] = rand_coord(eff_half(half_h));
      end
      made = 0;
      paused = 0;
      if (fill_first) begin
         // fill one cell to capacity and one past it
         for (int k = 0; k <= BIN_CAP; k++)
            add_op(ACT_REGISTER, hot_x[0], hot_y[0], ID_W'($urandom), SLOT_W'($urandom),
                   1'($urandom));
         made = BIN_CAP + 1;
      end
      while (made < count) begin
         if (made >= count / 2 && !paused) begin
            pause_next = 1;
            paused = 1;
         end
         pick = $urandom_range(0, 99);
         hsel = $urandom_range(0, 3);
         x = hot_x[hsel];
         y = hot_y[hsel];
         if (pick < 40) begin
            if ($urandom_range(0, 4) == 0) begin
               x = rand_coord(eff_half(half_w));
               y = rand_coord(eff_half(half_h));
            end
            bin_idx = cell_of(x, y);
            run = ($urandom_range(0, 9) == 0) ? BIN_CAP + 1 - gen_fill[bin_idx]
                                              : $urandom_range(1, 4);
            for (int k = 0; k < run; k++)
               add_op(ACT_REGISTER, x, y, ID_W'($urandom), SLOT_W'($urandom), 1'($urandom));
            made += run;
         end else if (pick < 70) begin
            bin_idx = cell_of(x, y);
            // sometimes drain the cell completely
            run = ($urandom_range(0, 3) == 0) ? gen_fill[bin_idx] : 1;
            if (run == 0) run = 1;
            for (int k = 0; k < run; k++)
               add_op(ACT_UNREGISTER, x, y, ID_W'($urandom),
                      (gen_fill[bin_idx] == 0)
                         ? SLOT_W'($urandom)
                         : SLOT_W'($urandom_range(0, gen_fill[bin_idx] - 1)),
                      1'($urandom));
            made += run;
         end else if (pick < 78) begin
            bin_idx = cell_of(x, y);
            add_op(ACT_UNREGISTER, x, y, ID_W'($urandom),
                   (gen_fill[bin_idx] < BIN_CAP)
                      ? SLOT_W'($urandom_range(gen_fill[bin_idx], BIN_CAP - 1))
                      : SLOT_W'($urandom),
                   1'($urandom));
            made++;
         end else if (pick < 88) begin
            if ($urandom_range(0, 1) == 1) begin
               x = rand_coord(eff_half(half_w));
               y = rand_coord(eff_half(half_h));
            end
            add_op(($urandom_range(0, 1) == 1) ? ACT_SET_CULL : ACT_READ_FLAG, x, y,
                   ID_W'($urandom), SLOT_W'($urandom), 1'($urandom));
            made++;
         end else if (pick < 97) begin
            if ($urandom_range(0, 1) == 1) begin
               x = rand_coord(eff_half(half_w));
               y = rand_coord(eff_half(half_h));
            end
            add_op(ACT_NEIGHBOURS, x, y, ID_W'($urandom), SLOT_W'($urandom), 1'($urandom));
            made++;
         end else begin
            add_op(ACT_W'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI)), x, y,
                   ID_W'($urandom), SLOT_W'($urandom), 1'($urandom));
            made++;
         end
      end
      wait_idle();
   endtask

   task automatic flag_mismatch(input string what);
      mismatches++;
      if (mismatches <= 10) $display("MISMATCH at %0t: %s", $realtime, what);
   endtask

   // Sender: bursts of items separated by random gaps.
   int gap_left = 0;
   int burst_left = 1;
   bit lane_free;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         lane_free = !req_valid;
         if (req_valid && req_ready) begin
            apply_bin_op(cur_op);
            ops_taken++;
            lane_free = 1;
         end
         if (lane_free) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (queued_ops.size() != 0 &&
                         !(queued_ops[0].pause && due_bin_results.size() != 0)) begin
               cur_op = queued_ops.pop_front();
               req_action <= cur_op.action;
               req_cell_x <= cur_op.cx;
               req_cell_y <= cur_op.cy;
               req_object_id <= cur_op.obj;
               req_slot_index <= cur_op.slot;
               req_culled <= cur_op.culled;
               req_valid <= 1'b1;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 30)
                                                           : $urandom_range(1, 8);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: stall pattern switches at random among four modes.
   ready_mode_type ready_mode = RDY_ALWAYS;
   int             mode_left = 0;
   int             stall_left = 0;
   int             tick = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            ready_mode = ready_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 80);
         end
         mode_left--;
         tick++;
         case (ready_mode)
            RDY_ALWAYS: rsp_ready <= 1'b1;
            RDY_THIRD:  rsp_ready <= (tick % 3 == 0);
            RDY_COIN:   rsp_ready <= 1'($urandom);
            default: begin
               if (stall_left > 0) begin
                  stall_left--;
                  rsp_ready <= 1'b0;
               end else begin
                  rsp_ready <= 1'b1;
                  stall_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
               end
            end
         endcase
      end
   end

   bin_result_type got;
   bin_result_type want;

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         got.status = rsp_status;
         got.slot = rsp_assigned_slot;
         got.moved = rsp_moved_object;
         got.moved_valid = rsp_moved_valid;
         got.in_frustum = rsp_in_frustum;
         got.nx = rsp_neighbour_x;
         got.ny = rsp_neighbour_y;
         got.active = rsp_active_cells;
         got.last = rsp_last;
         results_seen++;
         if (due_bin_results.size() == 0) begin
            flag_mismatch({"item with nothing due: ", result_text(got)});
         end else begin
            want = due_bin_results.pop_front();
            if (got.status !== want.status || got.slot !== want.slot ||
                got.moved !== want.moved || got.moved_valid !== want.moved_valid ||
                got.in_frustum !== want.in_frustum || got.nx !== want.nx ||
                got.ny !== want.ny || got.active !== want.active || got.last !== want.last)
               flag_mismatch({"expected ", result_text(want), " got ", result_text(got)});
         end
      end
   end

   initial begin
      clear_bins();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      settings_used = 1;

      // Directed: reset geometry 4x4, corners, aliased and clamped coordinates.
      add_op(ACT_REGISTER, -5'sd2, -5'sd2, 16'h0000, 4'd0, 1'b0);
      add_op(ACT_REGISTER, 5'sd2, 5'sd2, 16'hFFFF, 4'd15, 1'b1);
      add_op(ACT_REGISTER, 5'sd0, 5'sd0, 16'h1234, 4'd0, 1'b0);
      add_op(ACT_REGISTER, 5'sd15, 5'sb10000, 16'h00FF, 4'd0, 1'b0);
      add_op(ACT_READ_FLAG, 5'sd1, 5'sd1, 16'h0000, 4'd0, 1'b0);
      add_op(ACT_SET_CULL, 5'sd1, 5'sd1, 16'h0000, 4'd0, 1'b0);
      add_op(ACT_SET_CULL, -5'sd1, 5'sd2, 16'h0000, 4'd0, 1'b1);
      add_op(ACT_READ_FLAG, 5'sd0, 5'sd1, 16'h0000, 4'd0, 1'b1);
      add_op(ACT_NEIGHBOURS, -5'sd2, -5'sd2, 16'h0000, 4'd0, 1'b0);
      add_op(ACT_NEIGHBOURS, 5'sd1, 5'sd1, 16'h0000, 4'd0, 1'b0);
      add_op(ACT_NEIGHBOURS, 5'sd2, -5'sd1, 16'h0000, 4'd0, 1'b0);
      // bad unregisters: empty cell, slot past the fill
      add_op(ACT_UNREGISTER, -5'sd1, -5'sd1, 16'h0000, 4'd0, 1'b0);
      add_op(ACT_UNREGISTER, 5'sd2, 5'sd2, 16'h0000, 4'd15, 1'b0);
      add_op(ACT_REGISTER, 5'sd2, 5'sd2, 16'hAAAA, 4'd0, 1'b0);
      add_op(ACT_REGISTER, 5'sd2, 5'sd2, 16'h5555, 4'd0, 1'b0);
      add_op(ACT_UNREGISTER, 5'sd2, 5'sd2, 16'h0000, 4'd0, 1'b0);
      add_op(ACT_UNREGISTER, 5'sd2, 5'sd2, 16'h0000, 4'd1, 1'b0);
      // empty the first active cell, then the one swapped into its place
      add_op(ACT_UNREGISTER, -5'sd2, -5'sd2, 16'h0000, 4'd0, 1'b0);
      add_op(ACT_UNREGISTER, 5'sd2, -5'sd2, 16'h0000, 4'd0, 1'b0);
      add_op(ACT_UNREGISTER, 5'sd2, 5'sd2, 16'h0000, 4'd0, 1'b0);
      add_op(ACT_UNUSED_LO, 5'sd1, 5'sd1, 16'hFFFF, 4'd15, 1'b1);
      add_op(ACT_UNUSED_HI, -5'sd1, 5'sd1, 16'hFFFF, 4'd15, 1'b1);
      wait_idle();

      random_phase(4'd1, 4'd1, 40, 1);
      random_phase(4'd8, 4'd8, 26, 0);
      random_phase(4'd0, 4'd15, 26, 0);
      random_phase(4'd15, 4'd0, 26, 0);
      random_phase(CFG_W'($urandom), CFG_W'($urandom), 26, 0);

      $display("covered %0d items and %0d results over %0d grid settings, %0d mismatches",
               ops_taken, results_seen, settings_used, mismatches);
      if (mismatches == 0) begin
         $display("grid_cell_object_bins_unit_tb OK");
      end else begin
         $display("grid_cell_object_bins_unit_tb NOT OK");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("timeout with %0d results still due", due_bin_results.size());
      $display("grid_cell_object_bins_unit_tb NOT OK");
      $finish;
   end

endmodule
